// File: hdl/ostb_pkg.sv
// Shared types, codes and constants of the one-shot timer bank.
`default_nettype none
package ostb_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int MAX_TIMERS     = 64;
    localparam int CNT_W          = 29;
    localparam int MASK_W         = 8;
    localparam int REQ_W          = 2;
    localparam int ID_W           = 3;
    localparam int MS_W           = 32;
    localparam int S_DATA_W       = 40;
    localparam int M_DATA_W       = 16;

    // Division by the tick length of 10 ms as a multiply by a reciprocal.
    localparam logic [MS_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int              DIV10_SHIFT = 35;

    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

    typedef struct packed {
        logic capture;
        logic start_wr;
        logic stop_wr;
        logic walk_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             rd_done;
        logic             out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: hdl/one_shot_timer_bank_top.sv
// Top level of the one-shot timer bank: stream ports, controller and datapath.
//
// Each input request yields exactly one result. A start or stop request goes from acceptance
// through the decode state to the result state, where its result is registered once the
// output is free; a tick request also passes through the walk state, which walks the timers
// one per cycle through the single read and write port of the count and period memories. The
// next request is accepted once the result is registered, even if it has not yet been taken.
// The start period is divided by 10 with a reciprocal multiply in the accept cycle. No
// clearing pass follows reset: counts and periods are only used for armed timers, and
// a start writes both as it arms the timer.
`default_nettype none
module one_shot_timer_bank_top
    import ostb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // timer_id[2:0], period_ms[34:3], notify_on_expiry[35], zero fill [39:36]
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    // req_type[1:0]
    input  wire logic [REQ_W-1:0]    i_s_tuser,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // expired_mask[7:0], running_mask[15:8]
    output logic [M_DATA_W-1:0]      o_m_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    ostb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    ostb_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_type         (i_s_tuser),
        .i_timer_id         (i_s_tdata[ID_W-1:0]),
        .i_period_ms        (i_s_tdata[ID_W +: MS_W]),
        .i_notify_on_expiry (i_s_tdata[ID_W+MS_W]),
        .i_m_tready         (i_m_tready),
        .o_m_tvalid         (o_m_tvalid),
        .o_m_tdata          (o_m_tdata),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts)
    );

endmodule
`default_nettype wire

// File: hdl/ostb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ostb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hdl/ostb_ctrl.sv
// Controller state machine of the one-shot timer bank.
`default_nettype none
module ostb_ctrl
    import ostb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESULT;
                unique case (i_sts.req)
                    REQ_TICK: begin
                        o_cmd.walk_rd = 1'b1;
                        n_state       = S_WALK;
                    end
                    REQ_START: o_cmd.start_wr = 1'b1;
                    REQ_STOP:  o_cmd.stop_wr  = 1'b1;
                    default:   n_state = S_RESULT;
                endcase
            end
            S_WALK: begin
                if (i_sts.rd_done) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.walk_rd = 1'b1;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: hdl/ostb_dp.sv
// Datapath of the one-shot timer bank: timer state, tick walk and result register.
`default_nettype none
module ostb_dp
    import ostb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [REQ_W-1:0]    i_req_type,
    input  wire logic [ID_W-1:0]     i_timer_id,
    input  wire logic [MS_W-1:0]     i_period_ms,
    input  wire logic                i_notify_on_expiry,
    input  wire logic                i_m_tready,
    output logic                     o_m_tvalid,
    output logic [M_DATA_W-1:0]      o_m_tdata,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    logic [REQ_W-1:0]      r_req;
    logic [ID_W-1:0]       r_id;
    logic                  r_nfy;
    logic [CNT_W-1:0]      r_quot;
    logic [NUM_TIMERS-1:0] r_armed;
    logic [NUM_TIMERS-1:0] r_notify;
    logic [MASK_W-1:0]     r_exp;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_rd_done;
    logic                  r_wr_vld;
    logic [IDX_W-1:0]      r_wr_idx;
    logic                  r_out_vld;
    logic [M_DATA_W-1:0]   r_out_data;

    logic [2*MS_W-1:0]     w_prod;
    logic [CNT_W-1:0]      w_cnt_q;
    logic [CNT_W-1:0]      w_per_q;
    logic [CNT_W-1:0]      w_cnt_nxt;
    logic                  w_expire;
    logic                  w_in_range;
    logic [IDX_W-1:0]      w_start_idx;
    logic                  w_walk_we;
    logic                  w_cnt_we;
    logic [IDX_W-1:0]      w_cnt_waddr;
    logic [CNT_W-1:0]      w_cnt_wdata;
    logic                  w_per_we;
    logic [MASK_W-1:0]     w_run;

    assign w_prod      = {{MS_W{1'b0}}, i_period_ms} * {{MS_W{1'b0}}, DIV10_RECIP};
    assign w_in_range  = 32'(r_id) < 32'(NUM_TIMERS);
    assign w_start_idx = IDX_W'(r_id);
    assign w_cnt_nxt   = CNT_W'(w_cnt_q + CNT_W'(1));
    assign w_expire    = w_cnt_nxt > w_per_q;
    assign w_walk_we   = r_wr_vld && r_armed[r_wr_idx];
    assign w_per_we    = i_cmd.start_wr && w_in_range;
    assign w_cnt_we    = w_per_we || w_walk_we;
    assign w_cnt_waddr = i_cmd.start_wr ? w_start_idx : r_wr_idx;
    assign w_cnt_wdata = i_cmd.start_wr ? '0 : w_cnt_nxt;

    ostb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_TIMERS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (w_cnt_q)
    );

    ostb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_TIMERS)
    ) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (w_per_we),
        .i_waddr (w_start_idx),
        .i_wdata (r_quot),
        .i_raddr (r_rd_idx),
        .o_rdata (w_per_q)
    );

    for (genvar g = 0; g < MASK_W; g++) begin : g_run
        if (g < NUM_TIMERS) begin : g_on
            assign w_run[g] = r_armed[g];
        end else begin : g_off
            assign w_run[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= '0;
            r_notify  <= '0;
            r_rd_done <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_idx  <= '0;
            r_req     <= REQ_TICK;
        end else begin
            if (i_cmd.capture) begin
                r_req     <= i_req_type;
                r_id      <= i_timer_id;
                r_nfy     <= i_notify_on_expiry;
                r_quot    <= w_prod[DIV10_SHIFT +: CNT_W];
                r_exp     <= '0;
                r_rd_idx  <= '0;
                r_rd_done <= 1'b0;
            end
            r_wr_vld <= i_cmd.walk_rd;
            if (i_cmd.walk_rd) begin
                r_wr_idx  <= r_rd_idx;
                r_rd_done <= (r_rd_idx == LAST_IDX);
                if (r_rd_idx != LAST_IDX) begin
                    r_rd_idx <= IDX_W'(r_rd_idx + IDX_W'(1));
                end
            end
            if (w_walk_we && w_expire) begin
                r_armed[r_wr_idx] <= 1'b0;
                if (r_notify[r_wr_idx]) begin
                    r_notify[r_wr_idx] <= 1'b0;
                    if (32'(r_wr_idx) < 32'(MASK_W)) begin
                        r_exp[3'(r_wr_idx)] <= 1'b1;
                    end
                end
            end
            if (w_per_we) begin
                r_armed[w_start_idx]  <= 1'b1;
                r_notify[w_start_idx] <= r_nfy;
            end
            if (i_cmd.stop_wr && w_in_range) begin
                r_armed[w_start_idx] <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_out_vld  <= 1'b1;
                r_out_data <= {w_run, r_exp};
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid     = r_out_vld;
    assign o_m_tdata      = r_out_data;
    assign o_sts.req      = r_req;
    assign o_sts.rd_done  = r_rd_done;
    assign o_sts.out_free = !r_out_vld || i_m_tready;

    a_exp_not_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out_data[MASK_W-1:0] & r_out_data[M_DATA_W-1:MASK_W]) == '0))
        else $error("expired timer still shown as running");

    a_no_finish_mid_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wr_vld && i_cmd.finish))
        else $error("result loaded while the tick walk is still writing");

    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_per_we |=> r_armed[$past(w_start_idx)])
        else $error("start request did not arm its timer");

    a_walk_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_vld && $past(r_wr_vld)) |-> (r_wr_idx == IDX_W'($past(r_wr_idx) + IDX_W'(1))))
        else $error("tick walk skipped a timer");

endmodule
`default_nettype wire
